>>> src/gsm0710_basic_deframer_defines.svh
// ---------------------------------------------------------------------------
// GSM 07.10 deframer assertion macros
// Shared check forms, clocked on i_clk and quiet while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef GSM0710_BASIC_DEFRAMER_DEFINES_SVH
`define GSM0710_BASIC_DEFRAMER_DEFINES_SVH

// same-cycle implication
`define GDF_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gdf check failed");

// next-cycle implication
`define GDF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gdf check failed");

`endif

>>> src/gdf_pkg.sv
// ---------------------------------------------------------------------------
// GSM 07.10 deframer package
// Shared types, protocol constants and the CRC-8 step.
// ---------------------------------------------------------------------------
package gdf_pkg;

    localparam logic [7:0]  FLAG_BYTE     = 8'hF9;
    localparam logic [7:0]  CRC_INIT      = 8'hFF;
    localparam logic [7:0]  CRC_REV_POLY  = 8'hE0;
    localparam int          EA_BIT_POS    = 0;
    localparam int          PF_BIT_POS    = 4;
    localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
    localparam logic [16:0] ELAPSED_MAX   = 17'h1FFFF;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_BAD     = 2'd2,
        KIND_ABORT   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_CTRL  = 3'd1,
        PH_LEN1  = 3'd2,
        PH_LEN2  = 3'd3,
        PH_INFO  = 3'd4,
        PH_FCS   = 3'd5,
        PH_CLOSE = 3'd6
    } t_phase;

    typedef struct packed {
        logic       is_tick;
        logic       is_flag;
        logic [7:0] data;
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_head;

    // reflected CRC-8, poly 0x07, one byte
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_REV_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> src/gdf_front.sv
// ---------------------------------------------------------------------------
// GSM 07.10 deframer front end
// Accepts input beats, tags them as tick, flag or data, and queues them.
// ---------------------------------------------------------------------------
module gdf_front import gdf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,  // [7:0] rx_byte
    input  logic       i_s_tuser,  // [0] req_type
    input  logic       i_pop,
    output t_head      o_head
);

    t_op        r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    logic       push;
    t_op        in_op;

    assign o_s_tready = (r_count != 2'd2);
    assign push       = i_s_tvalid && o_s_tready;

    always_comb begin
        in_op.is_tick = (i_s_tuser == REQ_TICK);
        in_op.is_flag = (i_s_tdata == FLAG_BYTE);
        in_op.data    = i_s_tdata;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= in_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            case ({push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.op    = r_q[r_rd];

endmodule

>>> src/gdf_back.sv
// ---------------------------------------------------------------------------
// GSM 07.10 deframer back end
// Runs the frame state machine, CRC and timeout, and holds the result beat.
// ---------------------------------------------------------------------------
module gdf_back import gdf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_head       i_head,
    output logic        o_pop,
    input  logic        i_cfg_valid,
    input  logic [15:0] i_cfg_data,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,  // channel, frame_type, payload_byte, info_length, pad
    output logic [1:0]  o_m_tuser   // [1:0] out_kind
);

    t_phase      r_phase, n_phase;
    logic        r_flag_seen, n_flag_seen;
    logic [7:0]  r_addr, n_addr;
    logic [7:0]  r_ctrl, n_ctrl;
    logic [14:0] r_len, n_len;
    logic [14:0] r_icount, n_icount;
    logic [7:0]  r_crc, n_crc;
    logic        r_fcs_good, n_fcs_good;
    logic [16:0] r_elapsed, n_elapsed;
    logic [15:0] r_timeout;

    logic        r_out_valid;
    t_kind       r_out_kind;
    logic [5:0]  r_out_chan;
    logic [7:0]  r_out_ftype;
    logic [7:0]  r_out_pay;
    logic [14:0] r_out_len;

    logic        emit;
    t_kind       emit_kind;
    logic [7:0]  emit_pay;
    logic [7:0]  b;
    logic [7:0]  crc_next;
    logic [14:0] icount_inc;
    logic [16:0] elapsed_inc;

    assign o_pop       = i_head.valid && (!r_out_valid || i_m_tready);
    assign b           = i_head.op.data;
    assign crc_next    = crc8_step(r_crc, b);
    assign icount_inc  = r_icount + 15'd1;
    assign elapsed_inc = (r_elapsed < ELAPSED_MAX) ? r_elapsed + 17'd1 : r_elapsed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_valid) begin
            r_timeout <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_flag_seen <= 1'b0;
            r_addr      <= '0;
            r_ctrl      <= '0;
            r_len       <= '0;
            r_icount    <= '0;
            r_crc       <= CRC_INIT;
            r_fcs_good  <= 1'b0;
            r_elapsed   <= '0;
        end else if (o_pop) begin
            r_phase     <= n_phase;
            r_flag_seen <= n_flag_seen;
            r_addr      <= n_addr;
            r_ctrl      <= n_ctrl;
            r_len       <= n_len;
            r_icount    <= n_icount;
            r_crc       <= n_crc;
            r_fcs_good  <= n_fcs_good;
            r_elapsed   <= n_elapsed;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_flag_seen = r_flag_seen;
        n_addr      = r_addr;
        n_ctrl      = r_ctrl;
        n_len       = r_len;
        n_icount    = r_icount;
        n_crc       = r_crc;
        n_fcs_good  = r_fcs_good;
        n_elapsed   = r_elapsed;
        emit        = 1'b0;
        emit_kind   = KIND_PAYLOAD;
        emit_pay    = '0;

        if (i_head.op.is_tick) begin
            if (r_phase != PH_HUNT) begin
                n_elapsed = elapsed_inc;
                if (elapsed_inc > {1'b0, r_timeout}) begin
                    emit        = 1'b1;
                    emit_kind   = KIND_ABORT;
                    n_phase     = PH_HUNT;
                    n_flag_seen = 1'b0;
                end
            end
        end else begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_head.op.is_flag) begin
                        n_flag_seen = 1'b1;
                    end else if (r_flag_seen) begin
                        // address byte opens the frame
                        n_addr      = b;
                        n_ctrl      = '0;
                        n_len       = '0;
                        n_icount    = '0;
                        n_fcs_good  = 1'b0;
                        n_elapsed   = '0;
                        n_crc       = crc8_step(CRC_INIT, b);
                        n_flag_seen = 1'b0;
                        n_phase     = PH_CTRL;
                    end else begin
                        n_flag_seen = 1'b0;
                    end
                end
                PH_CTRL: begin
                    n_ctrl  = b;
                    n_crc   = crc_next;
                    n_phase = PH_LEN1;
                end
                PH_LEN1: begin
                    n_len = {8'd0, b[7:1]};
                    n_crc = crc_next;
                    if (b[EA_BIT_POS]) begin
                        n_phase = (b[7:1] == 7'd0) ? PH_FCS : PH_INFO;
                    end else begin
                        n_phase = PH_LEN2;
                    end
                end
                PH_LEN2: begin
                    n_len   = {b, r_len[6:0]};
                    n_crc   = crc_next;
                    n_phase = ({b, r_len[6:0]} == 15'd0) ? PH_FCS : PH_INFO;
                end
                PH_INFO: begin
                    n_icount = icount_inc;
                    if (icount_inc >= r_len) begin
                        n_phase = PH_FCS;
                    end
                    emit      = 1'b1;
                    emit_kind = KIND_PAYLOAD;
                    emit_pay  = b;
                end
                PH_FCS: begin
                    n_fcs_good = (b == ~r_crc);
                    n_phase    = PH_CLOSE;
                end
                PH_CLOSE: begin
                    emit        = 1'b1;
                    emit_kind   = r_fcs_good ? KIND_GOOD : KIND_BAD;
                    n_phase     = PH_HUNT;
                    n_flag_seen = 1'b0;
                end
                default: begin
                    n_phase     = PH_HUNT;
                    n_flag_seen = 1'b0;
                end
            endcase
        end
    end

    // result register: load on an emitting pop, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_out_kind  <= emit_kind;
            r_out_chan  <= r_addr[7:2];
            r_out_ftype <= r_ctrl & ~(8'd1 << PF_BIT_POS);
            r_out_pay   <= emit_pay;
            r_out_len   <= r_len;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tdata  = {3'd0, r_out_len, r_out_pay, r_out_ftype, r_out_chan};

endmodule

>>> src/gsm0710_basic_deframer.sv
// A beat's result is registered in the queue, then in the result register.
// Throughput: the state machine retires 1 queued beat per cycle unless the output stalls.
// Each beat gives at most one result; the result register decouples output stalls.
// Reset (i_rst_n low, synchronous): queue empty, hunting, timeout set to 5000 ticks.
// Configuration writes are always taken.
// ---------------------------------------------------------------------------
// GSM 07.10 basic-mode deframer
// Hunts for frames, streams info bytes and reports frame end or timeout.
// ---------------------------------------------------------------------------
`include "gsm0710_basic_deframer_defines.svh"

module gsm0710_basic_deframer import gdf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  logic        i_s_tuser,   // [0] req_type
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [5:0] channel, [13:6] frame_type,
                                     // [21:14] payload_byte, [36:22] info_length, [39:37] zero
    output logic [1:0]  o_m_tuser,   // [1:0] out_kind
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data   // [15:0] timeout_ticks
);

    t_head head;
    logic  pop;

    assign o_cfg_ready = 1'b1;

    gdf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_pop      (pop),
        .o_head     (head)
    );

    gdf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    `GDF_ASSERT_IMPL(a_no_pop_when_stalled, o_m_tvalid && !i_m_tready, !pop)
    `GDF_ASSERT_IMPL(a_pop_needs_head, pop, head.valid)
    `GDF_ASSERT_NEXT(a_head_holds, head.valid && !pop, head.valid)
    `GDF_ASSERT_IMPL(a_nonpayload_zero_byte,
        o_m_tvalid && (o_m_tuser != KIND_PAYLOAD), o_m_tdata[21:14] == 8'd0)

endmodule
